@@ hw/rtl/assert_macros.svh @@
// Assertion helpers, clocked on clk_i and disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define CSD_ASSERT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define CSD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CSD_ASSERT(name, ante, cons, msg)
`define CSD_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

@@ hw/rtl/csd_pkg.sv @@
package csd_pkg;

  // Fixed field widths
  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned LIMIT_W    = 23;
  localparam int unsigned TIME_W     = 24;
  localparam int unsigned ID_W       = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // Milliseconds per second, for the drift scaling
  localparam int unsigned MS_PER_S = 1000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OXY_RANGE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEL_RANGE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OXY_DRIFT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEL_DRIFT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RUN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 3'd5;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_CANCEL = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    PH_SETTLING  = 3'd0,
    PH_STABLE    = 3'd1,
    PH_SAVED     = 3'd2,
    PH_FAILED    = 3'd3,
    PH_CANCELLED = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LAUNCH,
    S_WALK,
    S_CALC,
    S_DECIDE,
    S_DIVIDE,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0]               opcode;
    logic                     use_helium;
    logic [ID_W-1:0]          request_id;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                     sample_finite;
    logic [TIME_W-1:0]        run_elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]          result_id;
    logic [2:0]               phase;
    logic signed [SAMPLE_W-1:0] last_sample;
    logic                     last_present;
    logic signed [SAMPLE_W-1:0] window_mean;
    logic [TIME_W-1:0]        report_elapsed_ms;
  } out_item_t;

endpackage

@@ hw/rtl/csd_stream_if.sv @@
interface csd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ hw/rtl/csd_window.sv @@
// Sample ring and the window walk: one entry read per cycle, oldest first,
// folded into min, max, total and the two half sums.
module csd_window #(
  parameter int unsigned W  = 8,
  parameter int unsigned SB = 24,
  parameter int unsigned AW = 3,
  parameter int unsigned TW = 28
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  logic [AW-1:0]        wr_slot_i,
  input  logic [SB-1:0]        wr_data_i,
  input  logic                 walk_start_i,
  input  logic [AW-1:0]        walk_base_i,
  output logic                 walk_done_o,
  output logic signed [SB-1:0] min_o,
  output logic signed [SB-1:0] max_o,
  output logic signed [TW-1:0] total_o,
  output logic signed [TW-1:0] older_o,
  output logic signed [TW-1:0] newer_o
);

  localparam int unsigned H = W / 2;

  logic [SB-1:0] ring_q [W];
  logic [SB-1:0] rd_data_q;

  logic          busy_q;
  logic [AW-1:0] iss_k_q;
  logic [AW-1:0] rd_ptr_q;
  logic          rd_vld_q;
  logic [AW-1:0] rd_k_q;
  logic          done_q;

  logic signed [SB-1:0] min_q, max_q;
  logic signed [TW-1:0] total_q, older_q, newer_q;
  logic signed [SB-1:0] v;
  logic signed [TW-1:0] v_ext;

  // Ring storage, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      ring_q[wr_slot_i] <= wr_data_i;
    end
    rd_data_q <= ring_q[rd_ptr_q];
  end

  // Read issue counter, wrapping pointer from the oldest entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      iss_k_q  <= '0;
      rd_ptr_q <= '0;
      rd_vld_q <= 1'b0;
      rd_k_q   <= '0;
      done_q   <= 1'b0;
    end else begin
      rd_vld_q <= busy_q;
      rd_k_q   <= iss_k_q;
      done_q   <= rd_vld_q && (rd_k_q == AW'(W - 1));
      if (walk_start_i) begin
        busy_q   <= 1'b1;
        iss_k_q  <= '0;
        rd_ptr_q <= walk_base_i;
      end else if (busy_q) begin
        rd_ptr_q <= (rd_ptr_q == AW'(W - 1)) ? '0 : rd_ptr_q + 1'b1;
        iss_k_q  <= iss_k_q + 1'b1;
        if (iss_k_q == AW'(W - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign v     = $signed(rd_data_q);
  assign v_ext = TW'(v);

  // Accumulate; the first entry seeds min, max, total and the older sum, and clears the newer sum
  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      if (rd_k_q == '0) begin
        min_q   <= v;
        max_q   <= v;
        total_q <= v_ext;
        older_q <= v_ext;
        newer_q <= '0;
      end else begin
        if (v < min_q) min_q <= v;
        if (v > max_q) max_q <= v;
        total_q <= total_q + v_ext;
        if (rd_k_q < AW'(H)) begin
          older_q <= older_q + v_ext;
        end else if (rd_k_q >= AW'(W - H)) begin
          newer_q <= newer_q + v_ext;
        end
      end
    end
  end

  assign walk_done_o = done_q;
  assign min_o       = min_q;
  assign max_o       = max_q;
  assign total_o     = total_q;
  assign older_o     = older_q;
  assign newer_o     = newer_q;

endmodule

@@ hw/rtl/calibration_stability_detector_top.sv @@
// Channel   Dir  Carries                     Transfer when
// req_i     in   start / sample / cancel     req_i.valid && req_i.ready
// rsp_o     out  run report                  rsp_o.valid && rsp_o.ready
// cfg_*     in   limit and time registers    cfg_we_i
//
// Start and cancel go straight to the report step; a sample before the window is full passes the decide step first.
// A full window is walked by one accumulator reading one ring entry a cycle,
// then checked in the calc and decide steps. A saved report adds a divide step
// for the mean, a multiply by the rounded-up reciprocal of the window size.
// req_i.ready is high only between items; a waiting report holds the next item
// in its last step, and the input with it. Reset is asynchronous; no ring clear.
`include "assert_macros.svh"

module calibration_stability_detector_top #(
  parameter int unsigned WINDOW_SAMPLES   = 8,
  parameter int unsigned SAMPLE_PERIOD_MS = 500,
  parameter int unsigned SAMPLE_BITS      = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [csd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [csd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  csd_stream_if.sink                       req_i,
  csd_stream_if.source                     rsp_o
);

  localparam int unsigned W   = WINDOW_SAMPLES;
  localparam int unsigned SB  = (SAMPLE_BITS < csd_pkg::SAMPLE_W) ? SAMPLE_BITS
                                                                  : csd_pkg::SAMPLE_W;
  localparam int unsigned AW  = $clog2(W);
  localparam int unsigned FW  = $clog2(W + 1);
  localparam int unsigned H   = W / 2;
  localparam int unsigned TW  = SB + $clog2(W) + 1;
  localparam int unsigned DW  = TW + 1;
  localparam int unsigned K   = H * (H + 1) * SAMPLE_PERIOD_MS;
  localparam int unsigned KW  = $clog2(K + 1);
  localparam int unsigned LW  = DW + $clog2(csd_pkg::MS_PER_S + 1);
  localparam int unsigned RW  = csd_pkg::LIMIT_W + KW;
  localparam int unsigned CW  = (LW > RW) ? LW : RW;
  localparam int unsigned GW  = (SB + 1 > csd_pkg::LIMIT_W) ? SB + 1 : csd_pkg::LIMIT_W;
  localparam int unsigned NW  = TW;
  // Reciprocal scaling: exact quotient for any dividend below 2**NW
  localparam int unsigned RS  = NW + $clog2(W);
  localparam int unsigned MW  = NW + 2;
  localparam int unsigned PW  = RS + NW + 2;
  localparam logic [MW-1:0] RECIP = MW'(((64'd1 << RS) + 64'(W) - 64'd1) / 64'(W));

  // Configuration registers
  logic [csd_pkg::LIMIT_W-1:0] oxy_rng_q, hel_rng_q, oxy_dft_q, hel_dft_q;
  logic [csd_pkg::TIME_W-1:0]  min_run_q, timeout_q;

  // Run state
  csd_pkg::state_e         state_q, state_d;
  logic                    run_active_q;
  logic                    helium_q;
  logic [csd_pkg::ID_W-1:0] held_id_q;
  logic [AW-1:0]           slot_q;
  logic [FW-1:0]           fill_q;
  logic [SB-1:0]           newest_q;

  // Current item
  logic [SB-1:0]               smp_q;
  logic                        fin_q;
  logic [csd_pkg::TIME_W-1:0]  elapsed_q;
  logic                        full_q;

  // Check and divide
  logic                range_ok_q;
  logic [CW-1:0]       lhs_q, rhs_q;
  logic                neg_q;
  logic [NW-1:0]       div_q;
  logic                mean_en_q;

  // Report staging and output register
  csd_pkg::out_item_t  res_q, out_q, res_out;
  logic                out_valid_q;

  // Window walk results
  logic                 walk_start, walk_done;
  logic signed [SB-1:0] min_w, max_w;
  logic signed [TW-1:0] total_w, older_w, newer_w;

  csd_pkg::in_item_t    item;
  logic                 accept, is_start, is_cancel, is_sample;
  logic [SB-1:0]        smp_in;
  logic [AW-1:0]        slot_inc;
  logic [FW-1:0]        fill_nx;
  logic                 full_nx;
  logic                 stable_c, save_c, fail_c, emit_go;
  logic [csd_pkg::LIMIT_W-1:0] rlim, dlim;
  logic [SB:0]          spread;
  logic signed [DW-1:0] diff;
  logic [DW-1:0]        ad;
  logic [NW-1:0]        tot_abs;
  logic [PW-1:0]        prod;
  logic signed [NW:0]   mean_s;
  logic signed [csd_pkg::SAMPLE_W-1:0] newest24, smp24, mean24;

  // Item decode
  assign item      = req_i.payload;
  assign accept    = req_i.valid && req_i.ready;
  assign is_start  = accept && (item.opcode == csd_pkg::OP_START) && !run_active_q;
  assign is_cancel = accept && (item.opcode == csd_pkg::OP_CANCEL) && run_active_q &&
                     (item.request_id == held_id_q);
  assign is_sample = accept && (item.opcode == csd_pkg::OP_SAMPLE) && run_active_q;
  assign smp_in    = item.sample_value[SB-1:0];
  assign slot_inc  = (slot_q == AW'(W - 1)) ? '0 : slot_q + 1'b1;
  assign fill_nx   = !item.sample_finite ? '0 :
                     (fill_q == FW'(W)) ? fill_q : fill_q + 1'b1;
  assign full_nx   = (fill_nx == FW'(W));

  // Stability and outcome
  assign rlim     = helium_q ? hel_rng_q : oxy_rng_q;
  assign dlim     = helium_q ? hel_dft_q : oxy_dft_q;
  assign spread   = {max_w[SB-1], max_w} - {min_w[SB-1], min_w};
  assign diff     = DW'(newer_w) - DW'(older_w);
  assign ad       = diff[DW-1] ? DW'(-diff) : DW'(diff);
  assign stable_c = full_q && range_ok_q && (lhs_q <= rhs_q);
  assign save_c   = stable_c && (elapsed_q >= min_run_q);
  assign fail_c   = elapsed_q >= timeout_q;
  assign tot_abs  = total_w[TW-1] ? NW'(-total_w) : NW'(total_w);

  // Divide by the window size through its reciprocal
  assign prod   = PW'(div_q) * PW'(RECIP);
  assign mean_s = neg_q ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
  assign mean24 = csd_pkg::SAMPLE_W'(mean_s);

  assign newest24 = csd_pkg::SAMPLE_W'($signed(newest_q));
  assign smp24    = csd_pkg::SAMPLE_W'($signed(smp_q));

  assign emit_go    = (state_q == csd_pkg::S_EMIT) && (!out_valid_q || rsp_o.ready);
  assign walk_start = (state_q == csd_pkg::S_LAUNCH);

  csd_window #(
    .W  (W),
    .SB (SB),
    .AW (AW),
    .TW (TW)
  ) u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_en_i      (is_sample && item.sample_finite),
    .wr_slot_i    (slot_q),
    .wr_data_i    (smp_in),
    .walk_start_i (walk_start),
    .walk_base_i  (slot_q),
    .walk_done_o  (walk_done),
    .min_o        (min_w),
    .max_o        (max_w),
    .total_o      (total_w),
    .older_o      (older_w),
    .newer_o      (newer_w)
  );

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oxy_rng_q <= 23'd256;
      hel_rng_q <= 23'd1280;
      oxy_dft_q <= 23'd64;
      hel_dft_q <= 23'd256;
      min_run_q <= 24'd10000;
      timeout_q <= 24'd120000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        csd_pkg::CFG_OXY_RANGE: oxy_rng_q <= cfg_data_i[csd_pkg::LIMIT_W-1:0];
        csd_pkg::CFG_HEL_RANGE: hel_rng_q <= cfg_data_i[csd_pkg::LIMIT_W-1:0];
        csd_pkg::CFG_OXY_DRIFT: oxy_dft_q <= cfg_data_i[csd_pkg::LIMIT_W-1:0];
        csd_pkg::CFG_HEL_DRIFT: hel_dft_q <= cfg_data_i[csd_pkg::LIMIT_W-1:0];
        csd_pkg::CFG_MIN_RUN:   min_run_q <= cfg_data_i[csd_pkg::TIME_W-1:0];
        csd_pkg::CFG_TIMEOUT:   timeout_q <= cfg_data_i[csd_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= csd_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      csd_pkg::S_IDLE: begin
        if (is_start || is_cancel) begin
          state_d = csd_pkg::S_EMIT;
        end else if (is_sample) begin
          state_d = full_nx ? csd_pkg::S_LAUNCH : csd_pkg::S_DECIDE;
        end
      end
      csd_pkg::S_LAUNCH: state_d = csd_pkg::S_WALK;
      csd_pkg::S_WALK: begin
        if (walk_done) state_d = csd_pkg::S_CALC;
      end
      csd_pkg::S_CALC:   state_d = csd_pkg::S_DECIDE;
      csd_pkg::S_DECIDE: state_d = save_c ? csd_pkg::S_DIVIDE : csd_pkg::S_EMIT;
      csd_pkg::S_DIVIDE: state_d = csd_pkg::S_EMIT;
      csd_pkg::S_EMIT: begin
        if (emit_go) state_d = csd_pkg::S_IDLE;
      end
      default: state_d = csd_pkg::S_IDLE;
    endcase
  end

  // Run control and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_active_q <= 1'b0;
      helium_q     <= 1'b0;
      held_id_q    <= '0;
      slot_q       <= '0;
      fill_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (is_start) begin
        run_active_q <= 1'b1;
        helium_q     <= item.use_helium;
        held_id_q    <= item.request_id;
        slot_q       <= '0;
        fill_q       <= '0;
      end
      if (is_cancel) begin
        run_active_q <= 1'b0;
      end
      if (is_sample) begin
        slot_q <= item.sample_finite ? slot_inc : '0;
        fill_q <= fill_nx;
      end
      if ((state_q == csd_pkg::S_DECIDE) && (save_c || fail_c)) begin
        run_active_q <= 1'b0;
      end
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Final report: the mean goes in only for a saved run
  always_comb begin
    res_out             = res_q;
    res_out.window_mean = mean_en_q ? mean24 : res_q.window_mean;
  end

  // Item capture, checks, divide and report staging
  always_ff @(posedge clk_i) begin
    if (is_sample) begin
      smp_q     <= smp_in;
      fin_q     <= item.sample_finite;
      elapsed_q <= item.run_elapsed_ms;
      full_q    <= full_nx;
      if (item.sample_finite) newest_q <= smp_in;
    end
    if (is_start) begin
      res_q.result_id         <= item.request_id;
      res_q.phase             <= csd_pkg::PH_SETTLING;
      res_q.last_sample       <= '0;
      res_q.last_present      <= 1'b0;
      res_q.window_mean       <= '0;
      res_q.report_elapsed_ms <= '0;
      mean_en_q               <= 1'b0;
    end
    if (is_cancel) begin
      res_q.result_id         <= held_id_q;
      res_q.phase             <= csd_pkg::PH_CANCELLED;
      res_q.last_sample       <= (fill_q != '0) ? newest24 : '0;
      res_q.last_present      <= (fill_q != '0);
      res_q.window_mean       <= '0;
      res_q.report_elapsed_ms <= item.run_elapsed_ms;
      mean_en_q               <= 1'b0;
    end
    // Spread check and cross-multiplied drift check
    if (state_q == csd_pkg::S_CALC) begin
      range_ok_q <= GW'(spread) <= GW'(rlim);
      lhs_q      <= CW'(ad) * CW'(csd_pkg::MS_PER_S);
      rhs_q      <= CW'(dlim) * CW'(K);
    end
    if (state_q == csd_pkg::S_DECIDE) begin
      res_q.result_id         <= held_id_q;
      res_q.window_mean       <= '0;
      res_q.report_elapsed_ms <= elapsed_q;
      mean_en_q               <= save_c;
      if (save_c || fail_c) begin
        res_q.phase        <= save_c ? csd_pkg::PH_SAVED : csd_pkg::PH_FAILED;
        res_q.last_sample  <= (fill_q != '0) ? newest24 : '0;
        res_q.last_present <= (fill_q != '0);
      end else begin
        res_q.phase        <= stable_c ? csd_pkg::PH_STABLE : csd_pkg::PH_SETTLING;
        res_q.last_sample  <= fin_q ? smp24 : '0;
        res_q.last_present <= fin_q;
      end
      // Magnitude plus half the divisor gives round half away from zero
      div_q <= tot_abs + NW'(H);
      neg_q <= total_w[TW-1];
    end
    if (state_q == csd_pkg::S_DIVIDE) begin
      div_q <= prod[RS +: NW];
    end
    if (emit_go) begin
      out_q <= res_out;
    end
  end

  assign req_i.ready   = (state_q == csd_pkg::S_IDLE);
  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

  `CSD_ASSERT(a_fill_bound, 1'b1, fill_q <= FW'(W), "fill count beyond window size")
  `CSD_ASSERT(a_slot_bound, 1'b1, slot_q <= AW'(W - 1), "write slot beyond ring")
  `CSD_ASSERT(a_walk_done, walk_done, state_q == csd_pkg::S_WALK, "walk done outside walk")
  `CSD_ASSERT(a_run_end, $fell(run_active_q), state_q != csd_pkg::S_IDLE, "run ended in idle")
  `CSD_ASSERT_NEXT(a_idle_after_emit, emit_go, state_q == csd_pkg::S_IDLE, "no return to idle")

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import csd_pkg::*;

  localparam int WINDOW        = 8;
  localparam int HALF          = WINDOW / 2;
  localparam int PERIOD_MS     = 500;
  localparam int SETTLE_CYCLES = 64;
  localparam int QUIET_LIMIT   = 2000;
  localparam int PHASE_ITEMS   = 240;

  // Register index the block does not decode
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  // Opcode the block ignores
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Register setting styles for the first three phases; the other phases get random settings
  localparam int SET_TIGHT   = 0;
  localparam int SET_LOOSE   = 1;
  localparam int SET_INSTANT = 2;

  // Idle odds per phase (one in N); zero means no idling
  localparam int IDLE_ODDS [6] = '{4, 8, 0, 3, 6, 0};

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  csd_stream_if #(.payload_t(in_item_t))  req_if ();
  csd_stream_if #(.payload_t(out_item_t)) rsp_if ();

  calibration_stability_detector_top #(
    .WINDOW_SAMPLES  (WINDOW),
    .SAMPLE_PERIOD_MS(PERIOD_MS),
    .SAMPLE_BITS     (SAMPLE_W)
  ) dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .req_i     (req_if),
    .rsp_o     (rsp_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  in_item_t  pending_requests [$];
  out_item_t expected_reports [$];
  out_item_t oldest_report;
  logic      req_loaded = 1'b0;
  int        send_gap = 0;
  int        stall_left = 0;
  int        idle_odds = 0;
  int        queued = 0;
  int        fail_count = 0;
  int        quiet_cycles = 0;

  // Shadow of the detector state and registers
  logic                       run_on = 1'b0;
  logic                       helium_run = 1'b0;
  logic [ID_W-1:0]            run_id = '0;
  logic signed [SAMPLE_W-1:0] ring [WINDOW];
  int                         slot = 0;
  int                         fill = 0;
  logic [LIMIT_W-1:0]         oxy_range_lim = 23'd256;
  logic [LIMIT_W-1:0]         hel_range_lim = 23'd1280;
  logic [LIMIT_W-1:0]         oxy_drift_lim = 23'd64;
  logic [LIMIT_W-1:0]         hel_drift_lim = 23'd256;
  logic [TIME_W-1:0]          min_run_ms = 24'd10000;
  logic [TIME_W-1:0]          timeout_lim_ms = 24'd120000;

  // End the run: report the newest window entry, if any
  task automatic close_run(input phase_e ph, input longint avg, input logic [TIME_W-1:0] ms);
    out_item_t rep;
    rep = '0;
    rep.result_id = run_id;
    rep.phase = ph;
    if (fill != 0) begin
      rep.last_present = 1'b1;
      rep.last_sample = ring[(slot + WINDOW - 1) % WINDOW];
    end
    rep.window_mean = avg[SAMPLE_W-1:0];
    rep.report_elapsed_ms = ms;
    expected_reports.push_back(rep);
    run_on = 1'b0;
  endtask

  // Work out the report (if any) caused by one accepted request
  task automatic predict_report(input in_item_t it);
    out_item_t rep;
    longint    v, lo, hi, total, older, newer, spread_lim, drift_lim, gap;
    logic      steady;
    rep = '0;
    lo = 0;
    hi = 0;
    total = 0;
    older = 0;
    newer = 0;
    case (it.opcode)
      OP_START: begin
        if (!run_on) begin
          run_on = 1'b1;
          helium_run = it.use_helium;
          run_id = it.request_id;
          slot = 0;
          fill = 0;
          rep.result_id = it.request_id;
          rep.phase = PH_SETTLING;
          expected_reports.push_back(rep);
        end
      end
      OP_CANCEL: begin
        if (run_on && it.request_id == run_id)
          close_run(PH_CANCELLED, 0, it.run_elapsed_ms);
      end
      OP_SAMPLE: begin
        if (run_on) begin
          // a non-finite reading empties the window
          if (it.sample_finite) begin
            ring[slot] = it.sample_value;
            slot = (slot + 1) % WINDOW;
            if (fill < WINDOW) fill++;
          end else begin
            fill = 0;
            slot = 0;
          end
          steady = (fill == WINDOW);
          if (steady) begin
            // oldest entry first
            for (int k = 0; k < WINDOW; k++) begin
              v = ring[(slot + k) % WINDOW];
              if (k == 0 || v < lo) lo = v;
              if (k == 0 || v > hi) hi = v;
              total += v;
              if (k < HALF) older += v;
              else if (k >= WINDOW - HALF) newer += v;
            end
            spread_lim = helium_run ? hel_range_lim : oxy_range_lim;
            drift_lim = helium_run ? hel_drift_lim : oxy_drift_lim;
            gap = newer - older;
            if (gap < 0) gap = -gap;
            steady = (hi - lo <= spread_lim) &&
                     (gap * MS_PER_S <= drift_lim * HALF * (HALF + 1) * PERIOD_MS);
          end
          if (steady && it.run_elapsed_ms >= min_run_ms) begin
            // mean rounded to nearest, ties away from zero
            if (total >= 0) v = (total + WINDOW / 2) / WINDOW;
            else v = -((-total + WINDOW / 2) / WINDOW);
            close_run(PH_SAVED, v, it.run_elapsed_ms);
          end else if (it.run_elapsed_ms >= timeout_lim_ms) begin
            close_run(PH_FAILED, 0, it.run_elapsed_ms);
          end else begin
            rep.result_id = run_id;
            rep.phase = steady ? PH_STABLE : PH_SETTLING;
            rep.last_present = it.sample_finite;
            rep.last_sample = it.sample_finite ? it.sample_value : '0;
            rep.report_elapsed_ms = it.run_elapsed_ms;
            expected_reports.push_back(rep);
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic void check_field(input string name, input logic [23:0] want,
                                      input logic [23:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  function automatic in_item_t make_item(input logic [1:0] op, input logic helium,
                                         input logic [ID_W-1:0] id,
                                         input logic [SAMPLE_W-1:0] value,
                                         input logic finite, input logic [TIME_W-1:0] ms);
    in_item_t it;
    it.opcode = op;
    it.use_helium = helium;
    it.request_id = id;
    it.sample_value = value;
    it.sample_finite = finite;
    it.run_elapsed_ms = ms;
    return it;
  endfunction

  function automatic void queue_item(input in_item_t it);
    pending_requests.push_back(it);
    queued++;
  endfunction

  function automatic void queue_noise();
    queue_item(make_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                         ID_W'($urandom_range(0, 65535)), SAMPLE_W'($urandom()),
                         1'($urandom_range(0, 1)), TIME_W'($urandom())));
  endfunction

  // One calibration run: start, a stream of readings, usually a cancel
  task automatic queue_run();
    logic [ID_W-1:0]            id;
    logic signed [SAMPLE_W-1:0] seed_val;
    longint                     base, slope, v, t;
    int                         amp, n;
    id = ID_W'($urandom_range(0, 65535));
    seed_val = SAMPLE_W'($urandom());
    base = seed_val;
    case ($urandom_range(0, 6))
      0: amp = 0;
      1: amp = 1;
      2: amp = 8;
      3: amp = 64;
      4: amp = 512;
      5: amp = 4096;
      default: amp = 1 << 22;
    endcase
    case ($urandom_range(0, 4))
      0, 1: slope = 0;
      2: slope = 1;
      3: slope = 16;
      default: slope = 200;
    endcase
    n = $urandom_range(1, 24);
    t = 0;
    queue_item(make_item(OP_START, 1'($urandom_range(0, 1)), id, SAMPLE_W'($urandom()),
                         1'($urandom_range(0, 1)), TIME_W'($urandom())));
    for (int i = 0; i < n; i++) begin
      t += 500 + $urandom_range(0, 40);
      if ($urandom_range(0, 39) == 0) t += $urandom_range(0, 100000);
      if ($urandom_range(0, 59) == 0 || t > 24'hFFFFFF) t = 24'hFFFFFF;
      v = base + slope * i + longint'($urandom_range(0, 2 * amp)) - amp;
      if (v > 8388607) v = 8388607;
      if (v < -8388608) v = -8388608;
      queue_item(make_item(OP_SAMPLE, 1'($urandom_range(0, 1)),
                           ID_W'($urandom_range(0, 65535)),
                           v[SAMPLE_W-1:0], $urandom_range(0, 29) != 0, t[TIME_W-1:0]));
      // occasional stray start or cancel for another run
      if ($urandom_range(0, 19) == 0)
        queue_item(make_item($urandom_range(0, 1) ? OP_START : OP_CANCEL,
                             1'($urandom_range(0, 1)), ID_W'(id + $urandom_range(1, 65535)),
                             SAMPLE_W'($urandom()), 1'($urandom_range(0, 1)),
                             t[TIME_W-1:0]));
    end
    if ($urandom_range(0, 3) != 0)
      queue_item(make_item(OP_CANCEL, 1'($urandom_range(0, 1)), id, SAMPLE_W'($urandom()),
                           1'($urandom_range(0, 1)), t[TIME_W-1:0]));
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    case (idx)
      CFG_OXY_RANGE: oxy_range_lim = data[LIMIT_W-1:0];
      CFG_HEL_RANGE: hel_range_lim = data[LIMIT_W-1:0];
      CFG_OXY_DRIFT: oxy_drift_lim = data[LIMIT_W-1:0];
      CFG_HEL_DRIFT: hel_drift_lim = data[LIMIT_W-1:0];
      CFG_MIN_RUN:   min_run_ms = data;
      CFG_TIMEOUT:   timeout_lim_ms = data;
      default: ;
    endcase
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_setting(input int unsigned lo,
                                                         input int unsigned hi);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return CFG_DATA_W'($urandom_range(lo, hi));
    endcase
  endfunction

  task automatic load_settings(input int mode);
    logic [CFG_DATA_W-1:0] o_rng, h_rng, o_dft, h_dft, min_ms, tmo_ms;
    o_rng = pick_setting(0, 3000);
    h_rng = pick_setting(0, 6000);
    o_dft = pick_setting(0, 600);
    h_dft = pick_setting(0, 1200);
    min_ms = pick_setting(0, 9000);
    tmo_ms = pick_setting(1000, 40000);
    case (mode)
      SET_TIGHT: begin
        o_rng = '0;
        h_rng = '0;
        o_dft = '0;
        h_dft = '0;
        min_ms = '0;
        tmo_ms = '1;
      end
      SET_LOOSE: begin
        o_rng = '1;
        h_rng = '1;
        o_dft = '1;
        h_dft = '1;
        min_ms = '1;
        tmo_ms = '1;
      end
      SET_INSTANT: begin
        min_ms = '0;
        tmo_ms = '0;
      end
      default: ;
    endcase
    write_register(CFG_OXY_RANGE, o_rng);
    write_register(CFG_HEL_RANGE, h_rng);
    write_register(CFG_OXY_DRIFT, o_dft);
    write_register(CFG_HEL_DRIFT, h_dft);
    write_register(CFG_MIN_RUN, min_ms);
    write_register(CFG_TIMEOUT, tmo_ms);
    write_register(CFG_UNUSED, CFG_DATA_W'($urandom()));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait for every request and report, then let the block go quiet
  task automatic drain();
    while (pending_requests.size() != 0 || req_loaded || expected_reports.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        predict_report(req_if.payload);
        req_loaded = 1'b0;
      end
      if (!req_loaded) begin
        if (send_gap != 0) begin
          send_gap--;
          req_if.valid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          req_if.payload <= pending_requests.pop_front();
          req_if.valid <= 1'b1;
          req_loaded = 1'b1;
          if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
            send_gap = $urandom_range(1, 14);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Report monitor and back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected report, expected none, actual %h", $time, rsp_if.payload);
          fail_count++;
        end else begin
          oldest_report = expected_reports.pop_front();
          check_field("result_id", oldest_report.result_id, rsp_if.payload.result_id);
          check_field("phase", oldest_report.phase, rsp_if.payload.phase);
          check_field("last_sample", oldest_report.last_sample, rsp_if.payload.last_sample);
          check_field("last_present", oldest_report.last_present,
                      rsp_if.payload.last_present);
          check_field("window_mean", oldest_report.window_mean, rsp_if.payload.window_mean);
          check_field("report_elapsed_ms", oldest_report.report_elapsed_ms,
                      rsp_if.payload.report_elapsed_ms);
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
          stall_left = $urandom_range(1, 14);
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    req_if.valid = 1'b0;
    req_if.payload = '0;
    rsp_if.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at reset settings
    idle_odds = 4;
    queue_item(make_item(OP_SAMPLE, 1'b0, 16'h0000, 24'h000100, 1'b1, 24'd100));
    queue_item(make_item(OP_CANCEL, 1'b0, 16'h0000, 24'h000000, 1'b1, 24'd100));
    queue_item(make_item(OP_UNUSED, 1'b1, 16'hFFFF, 24'hFFFFFF, 1'b1, 24'hFFFFFF));
    queue_item(make_item(OP_START, 1'b0, 16'hFFFF, 24'h000000, 1'b0, 24'd0));
    // start while running is dropped, as is a cancel for another id
    queue_item(make_item(OP_START, 1'b1, 16'h00AA, 24'h000000, 1'b0, 24'd0));
    queue_item(make_item(OP_CANCEL, 1'b0, 16'hFFFE, 24'h000000, 1'b0, 24'd250));
    // flat window at full scale, stable before the minimum run time
    for (int i = 1; i <= WINDOW; i++)
      queue_item(make_item(OP_SAMPLE, 1'b0, 16'h0000, 24'h7FFFFF, 1'b1, 24'(500 * i)));
    queue_item(make_item(OP_SAMPLE, 1'b0, 16'h0000, 24'h123456, 1'b0, 24'd4500));
    queue_item(make_item(OP_CANCEL, 1'b0, 16'hFFFF, 24'h000000, 1'b0, 24'd4700));
    // helium run at negative full scale; saved wins over timeout
    queue_item(make_item(OP_START, 1'b1, 16'h0000, 24'h000000, 1'b0, 24'd0));
    for (int i = 1; i < WINDOW; i++)
      queue_item(make_item(OP_SAMPLE, 1'b0, 16'h0000, 24'h800000, 1'b1, 24'(500 * i)));
    queue_item(make_item(OP_SAMPLE, 1'b0, 16'h0000, 24'h800000, 1'b1, 24'hFFFFFF));
    // timeout on the first reading
    queue_item(make_item(OP_START, 1'b0, 16'h1234, 24'h000000, 1'b0, 24'd0));
    queue_item(make_item(OP_SAMPLE, 1'b0, 16'h1234, 24'h000000, 1'b1, 24'd120000));
    drain();

    // Random phases, each under its own register settings
    for (int p = 0; p < 6; p++) begin
      load_settings(p);
      idle_odds = IDLE_ODDS[p];
      queued = 0;
      while (queued < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) queue_noise();
        else queue_run();
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
